>>> hw/rtl/crf_pkg.sv
`timescale 1ns / 1ps

package crf_pkg;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int COEF_BITS_DEF = 8;
  localparam int KERNEL_SIZE   = 3;
  localparam int KERNEL_TAPS   = KERNEL_SIZE * KERNEL_SIZE;

  localparam int PIX_W        = 8;
  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 16;
  // rows run up to height + 1 before the frame restarts
  localparam int ROW_W        = HEIGHT_REG_W + 1;
  localparam int MODE_W       = 2;
  localparam int CFG_IDX_W    = 3;
  // line store word: {row r-2, row r-1}
  localparam int LB_W         = 2 * PIX_W;

  localparam int WIDTH_RESET  = 1024;
  localparam int HEIGHT_RESET = 768;

  localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

  localparam int DIV16_SHIFT  = 4;
  localparam int SOBEL_OFFSET = 4 * 255;
  localparam int SOBEL_SHIFT  = 3;
  // divide by 9 through a reciprocal, exact for sums below the clamp limit
  localparam int DIV9_LIMIT   = 9 * 256;
  localparam int DIV9_SHIFT   = 16;
  localparam int DIV9_RECIP   = (1 << DIV9_SHIFT) / 9 + 1;
  localparam int DIV9_IN_W    = 12;
  localparam int DIV9_RECIP_W = 13;

  localparam logic [MODE_W-1:0] SCALE_DIV9  = 2'd0;
  localparam logic [MODE_W-1:0] SCALE_DIV16 = 2'd1;
  localparam logic [MODE_W-1:0] SCALE_SOBEL = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_TOP     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_MID     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_BOT     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_MODE   = 3'd5;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             top_en;
    logic             mid_en;
    logic             col0;
    logic             emit;
    logic             frame_end;
    logic             restart;
  } crf_item_t;

endpackage

>>> hw/rtl/crf_in_if.sv
`timescale 1ns / 1ps

interface crf_in_if
  import crf_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_in;
  logic             flush;

  modport source (output valid, pixel_in, flush, input ready);
  modport sink (input valid, pixel_in, flush, output ready);
endinterface

>>> hw/rtl/crf_out_if.sv
`timescale 1ns / 1ps

interface crf_out_if
  import crf_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_out;
  logic             frame_end;

  modport source (output valid, pixel_out, frame_end, input ready);
  modport sink (input valid, pixel_out, frame_end, output ready);
endinterface

>>> hw/rtl/crf_line_buf.sv
`timescale 1ns / 1ps

module crf_line_buf
  import crf_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,
  localparam int ADDR_W = $clog2(MAX_WIDTH)
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [LB_W-1:0]   wr_data,
  output logic [LB_W-1:0]   rd_data
);

  logic [LB_W-1:0] mem [MAX_WIDTH];
  logic [LB_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // write-first on a same-address collision (one-pixel-wide rows)
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= (wr_en && (wr_addr == rd_addr)) ? wr_data : mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> hw/rtl/crf_raster_ctrl.sv
`timescale 1ns / 1ps

module crf_raster_ctrl
  import crf_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,
  localparam int ADDR_W = $clog2(MAX_WIDTH)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [PIX_W-1:0]        pixel_in,
  input  logic                    flush,
  input  logic [WIDTH_REG_W-1:0]  image_width,
  input  logic [HEIGHT_REG_W-1:0] image_height,
  input  logic                    s1_go,
  output logic                    rd_en,
  output logic [ADDR_W-1:0]       rd_addr,
  output logic                    s1_valid,
  output crf_item_t               s1_item,
  output logic [ADDR_W-1:0]       s1_col
);

  localparam int CNT_W = $clog2(MAX_WIDTH + 1);

  logic [ADDR_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic              s1_valid_r, s1_valid_nxt;
  crf_item_t         item_r, item_nxt;
  logic [ADDR_W-1:0] s1_col_r;

  logic [CNT_W-1:0]  width_eff;
  logic [CNT_W-1:0]  col_inc;
  logic [ROW_W-1:0]  height_eff;
  logic [ROW_W-1:0]  row_cur;
  logic [ADDR_W-1:0] col_cur;
  logic              wrap_early;
  logic              accept;

  always_comb begin
    if (image_width == '0) begin
      width_eff = CNT_W'(1);
    end else if (int'(image_width) > MAX_WIDTH) begin
      width_eff = CNT_W'(MAX_WIDTH);
    end else begin
      width_eff = CNT_W'(image_width);
    end
    height_eff = (image_height == '0) ? ROW_W'(1) : ROW_W'(image_height);
  end

  // a width lowered while mid-row ends that row here
  assign wrap_early = CNT_W'(col_r) >= width_eff;
  assign col_cur    = wrap_early ? '0 : col_r;
  assign row_cur    = wrap_early ? row_r + ROW_W'(1) : row_r;
  assign col_inc    = CNT_W'(col_cur) + CNT_W'(1);

  assign in_ready = !s1_valid_r || s1_go;
  assign accept   = in_valid && in_ready;

  always_comb begin
    item_nxt.col0      = (col_cur == '0);
    item_nxt.restart   = item_nxt.col0 && (row_cur >= height_eff + ROW_W'(1));
    item_nxt.top_en    = (row_cur >= ROW_W'(2)) && (row_cur < height_eff + ROW_W'(2));
    item_nxt.mid_en    = (row_cur >= ROW_W'(1)) && (row_cur < height_eff + ROW_W'(1));
    item_nxt.emit      = item_nxt.col0 ? item_nxt.top_en : item_nxt.mid_en;
    item_nxt.frame_end = item_nxt.col0 && (row_cur == height_eff + ROW_W'(1));
    item_nxt.pix       = (!flush && (row_cur < height_eff)) ? pixel_in : '0;

    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (item_nxt.restart) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (col_inc >= width_eff) begin
        col_nxt = '0;
        row_nxt = row_cur + ROW_W'(1);
      end else begin
        col_nxt = col_inc[ADDR_W-1:0];
        row_nxt = row_cur;
      end
    end

    s1_valid_nxt = accept || (s1_valid_r && !s1_go);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r   <= item_nxt;
      s1_col_r <= col_cur;
    end
  end

  assign rd_en    = accept;
  assign rd_addr  = col_cur;
  assign s1_valid = s1_valid_r;
  assign s1_item  = item_r;
  assign s1_col   = s1_col_r;

endmodule

>>> hw/rtl/crf_window_mac.sv
`timescale 1ns / 1ps

module crf_window_mac
  import crf_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,
  parameter int COEF_BITS = COEF_BITS_DEF,
  localparam int ADDR_W = $clog2(MAX_WIDTH),
  localparam int COEF_ROW_W = KERNEL_SIZE * COEF_BITS,
  localparam int PROD_W = COEF_BITS + PIX_W + 1
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     s1_valid,
  input  crf_item_t                s1_item,
  input  logic [ADDR_W-1:0]        s1_col,
  input  logic [LB_W-1:0]          rd_data,
  input  logic [COEF_ROW_W-1:0]    coef_rows [KERNEL_SIZE],
  input  logic                     s2_free,
  output logic                     s1_go,
  output logic                     wr_en,
  output logic [ADDR_W-1:0]        wr_addr,
  output logic [LB_W-1:0]          wr_data,
  output logic                     s2_valid,
  output logic                     s2_frame_end,
  output logic signed [PROD_W-1:0] s2_prod [KERNEL_TAPS]
);

  // window indexed [column][row], column 2 is the newest, row 0 the top
  logic [PIX_W-1:0]         win_r   [KERNEL_SIZE][KERNEL_SIZE];
  logic [PIX_W-1:0]         win_nxt [KERNEL_SIZE][KERNEL_SIZE];
  logic [PIX_W-1:0]         sh      [KERNEL_SIZE][KERNEL_SIZE];
  logic [PIX_W-1:0]         top_pix, mid_pix;
  logic signed [PROD_W-1:0] prod_nxt [KERNEL_TAPS];
  logic signed [PROD_W-1:0] prod_r   [KERNEL_TAPS];
  logic                     s2_valid_r, frame_end_r;
  logic                     load_s2;

  always_comb begin
    top_pix = s1_item.top_en ? rd_data[LB_W-1:PIX_W] : '0;
    mid_pix = s1_item.mid_en ? rd_data[PIX_W-1:0] : '0;

    sh[0] = win_r[1];
    sh[1] = win_r[2];
    // column 0 takes in zero padding to close the previous row
    if (s1_item.col0) begin
      sh[2] = '{default: '0};
    end else begin
      sh[2] = '{top_pix, mid_pix, s1_item.pix};
    end

    if (s1_item.restart) begin
      win_nxt = '{default: '0};
    end else if (s1_item.col0) begin
      win_nxt    = '{default: '0};
      win_nxt[2] = '{top_pix, mid_pix, s1_item.pix};
    end else begin
      win_nxt = sh;
    end
  end

  // flipped kernel: tap (v,u) meets column 2-u, row 2-v
  always_comb begin
    for (int v = 0; v < KERNEL_SIZE; v++) begin
      for (int u = 0; u < KERNEL_SIZE; u++) begin
        prod_nxt[v*KERNEL_SIZE+u] =
          PROD_W'($signed(coef_rows[v][u*COEF_BITS +: COEF_BITS])) *
          PROD_W'($signed({1'b0, sh[KERNEL_SIZE-1-u][KERNEL_SIZE-1-v]}));
      end
    end
  end

  assign s1_go   = s1_valid && (!s1_item.emit || s2_free);
  assign load_s2 = s1_go && s1_item.emit;

  assign wr_en   = s1_go && !s1_item.restart;
  assign wr_addr = s1_col;
  assign wr_data = {rd_data[PIX_W-1:0], s1_item.pix};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r      <= '{default: '0};
      s2_valid_r <= 1'b0;
    end else begin
      if (s1_go) begin
        win_r <= win_nxt;
      end
      if (load_s2) begin
        s2_valid_r <= 1'b1;
      end else if (s2_free) begin
        s2_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_s2) begin
      prod_r      <= prod_nxt;
      frame_end_r <= s1_item.frame_end;
    end
  end

  assign s2_valid     = s2_valid_r;
  assign s2_frame_end = frame_end_r;
  assign s2_prod      = prod_r;

endmodule

>>> hw/rtl/crf_scaler.sv
`timescale 1ns / 1ps

module crf_scaler
  import crf_pkg::*;
#(
  parameter int COEF_BITS = COEF_BITS_DEF,
  localparam int PROD_W = COEF_BITS + PIX_W + 1
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     s2_valid,
  input  logic                     s2_frame_end,
  input  logic signed [PROD_W-1:0] s2_prod [KERNEL_TAPS],
  input  logic [MODE_W-1:0]        scale_mode,
  output logic                     s2_free,
  crf_out_if.source                out_ch
);

  localparam int SUM_W       = PROD_W + $clog2(KERNEL_TAPS);
  localparam int SX_W        = SUM_W + 1;
  localparam int DIV9_PROD_W = DIV9_IN_W + DIV9_RECIP_W;

  localparam logic signed [SX_W-1:0] SOBEL_OFF_X = SX_W'(SOBEL_OFFSET);
  localparam logic signed [SX_W-1:0] DIV9_LIM_X  = SX_W'(DIV9_LIMIT);
  localparam logic signed [SX_W-1:0] PIX_MAX_X   = SX_W'(PIX_MAX);

  logic signed [SUM_W-1:0]  sum;
  logic signed [SX_W-1:0]   sum_x, sobel_sum, base, scaled;
  logic [DIV9_PROD_W-1:0]   div9_prod;
  logic [PIX_W-1:0]         pix_nxt, pix_r;
  logic                     out_valid_r, frame_end_r;
  logic                     out_free, load;

  always_comb begin
    sum = '0;
    for (int i = 0; i < KERNEL_TAPS; i++) begin
      sum = sum + SUM_W'(s2_prod[i]);
    end
    sum_x     = SX_W'(sum);
    sobel_sum = sum_x + SOBEL_OFF_X;
    // only used below the clamp limit, where the low bits hold the whole sum
    div9_prod = DIV9_PROD_W'(sum_x[DIV9_IN_W-1:0]) * DIV9_PROD_W'(DIV9_RECIP);

    unique case (scale_mode)
      SCALE_DIV16: begin
        base   = sum_x;
        scaled = sum_x >>> DIV16_SHIFT;
      end
      SCALE_SOBEL: begin
        base   = sobel_sum;
        scaled = sobel_sum >>> SOBEL_SHIFT;
      end
      default: begin
        base   = sum_x;
        scaled = (sum_x >= DIV9_LIM_X) ? PIX_MAX_X
                                       : SX_W'(div9_prod[DIV9_SHIFT +: PIX_W]);
      end
    endcase

    if (base[SX_W-1]) begin
      pix_nxt = '0;
    end else if (scaled > PIX_MAX_X) begin
      pix_nxt = PIX_MAX;
    end else begin
      pix_nxt = scaled[PIX_W-1:0];
    end
  end

  assign out_free = !out_valid_r || out_ch.ready;
  assign s2_free  = !s2_valid || out_free;
  assign load     = s2_valid && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pix_r       <= pix_nxt;
      frame_end_r <= s2_frame_end;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.pixel_out = pix_r;
  assign out_ch.frame_end = frame_end_r;

endmodule

>>> hw/rtl/conv3x3_raster_filter_unit.sv
`timescale 1ns / 1ps
// 3x3 convolution over an 8-bit grey frame streamed in raster order.
// in_pix carries one pixel per transaction (pixel_in, flush); after the last
// pixel of a frame the source sends image_width+1 flush transactions so the
// bottom row drains. out_pix carries one filtered pixel per transaction;
// frame_end marks the last pixel of the frame. Results start after the first
// image_width+1 input transactions of a frame.
// Throughput is one pixel per clock in both directions while out_pix does
// not stall. A result reaches out_pix through the line store read into the
// stage 1 register, the window update and tap products into the stage 2
// register, and the adder tree, scaling and clamp into the output register.
// The line stores are a single-port-write memory of MAX_WIDTH words, not
// cleared, since an entry is only used once written. Reset clears the row
// and column counters, the window and all valid flags and loads the register
// defaults (1024x768, identity kernel, divide by 9). Configuration is
// written through cfg_we/cfg_index/cfg_wdata by the user only while idle;
// the block does not enforce it. When out_pix stalls, both internal stages
// and the output register fill before in_pix.ready is held low.
module conv3x3_raster_filter_unit
  import crf_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,
  parameter int COEF_BITS = COEF_BITS_DEF,
  localparam int COEF_ROW_W = KERNEL_SIZE * COEF_BITS,
  localparam int CFG_DATA_W = (COEF_ROW_W > HEIGHT_REG_W) ? COEF_ROW_W : HEIGHT_REG_W
) (
  input  logic                  clk,
  input  logic                  rst_n,
  crf_in_if.sink                in_pix,
  crf_out_if.source             out_pix,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int ADDR_W = $clog2(MAX_WIDTH);
  localparam int PROD_W = COEF_BITS + PIX_W + 1;

  logic [WIDTH_REG_W-1:0]  image_width_r;
  logic [HEIGHT_REG_W-1:0] image_height_r;
  logic [COEF_ROW_W-1:0]   coef_r [KERNEL_SIZE];
  logic [MODE_W-1:0]       scale_mode_r;

  logic                     rd_en;
  logic [ADDR_W-1:0]        rd_addr;
  logic [LB_W-1:0]          rd_data;
  logic                     wr_en;
  logic [ADDR_W-1:0]        wr_addr;
  logic [LB_W-1:0]          wr_data;
  logic                     s1_valid, s1_go;
  crf_item_t                s1_item;
  logic [ADDR_W-1:0]        s1_col;
  logic                     s2_valid, s2_free, s2_frame_end;
  logic signed [PROD_W-1:0] s2_prod [KERNEL_TAPS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= WIDTH_REG_W'(WIDTH_RESET);
      image_height_r <= HEIGHT_REG_W'(HEIGHT_RESET);
      coef_r[0]      <= '0;
      coef_r[1]      <= COEF_ROW_W'(1 << COEF_BITS);
      coef_r[2]      <= '0;
      scale_mode_r   <= SCALE_DIV9;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:  image_width_r  <= cfg_wdata[WIDTH_REG_W-1:0];
        CFG_IMAGE_HEIGHT: image_height_r <= cfg_wdata[HEIGHT_REG_W-1:0];
        CFG_COEF_TOP:     coef_r[0]      <= cfg_wdata[COEF_ROW_W-1:0];
        CFG_COEF_MID:     coef_r[1]      <= cfg_wdata[COEF_ROW_W-1:0];
        CFG_COEF_BOT:     coef_r[2]      <= cfg_wdata[COEF_ROW_W-1:0];
        CFG_SCALE_MODE:   scale_mode_r   <= cfg_wdata[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  crf_raster_ctrl #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_pix.valid),
    .in_ready     (in_pix.ready),
    .pixel_in     (in_pix.pixel_in),
    .flush        (in_pix.flush),
    .image_width  (image_width_r),
    .image_height (image_height_r),
    .s1_go        (s1_go),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .s1_valid     (s1_valid),
    .s1_item      (s1_item),
    .s1_col       (s1_col)
  );

  crf_line_buf #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_buf (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

  crf_window_mac #(
    .MAX_WIDTH (MAX_WIDTH),
    .COEF_BITS (COEF_BITS)
  ) u_window (
    .clk          (clk),
    .rst_n        (rst_n),
    .s1_valid     (s1_valid),
    .s1_item      (s1_item),
    .s1_col       (s1_col),
    .rd_data      (rd_data),
    .coef_rows    (coef_r),
    .s2_free      (s2_free),
    .s1_go        (s1_go),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .s2_valid     (s2_valid),
    .s2_frame_end (s2_frame_end),
    .s2_prod      (s2_prod)
  );

  crf_scaler #(
    .COEF_BITS (COEF_BITS)
  ) u_scaler (
    .clk          (clk),
    .rst_n        (rst_n),
    .s2_valid     (s2_valid),
    .s2_frame_end (s2_frame_end),
    .s2_prod      (s2_prod),
    .scale_mode   (scale_mode_r),
    .s2_free      (s2_free),
    .out_ch       (out_pix)
  );

  // input only stalls behind an occupied first stage
  a_in_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_pix.ready |-> s1_valid)
    else $error("input stalled with stage 1 empty");

  // an item that carries a result is never dropped between the stages
  a_result_handoff: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && s1_item.emit |=> s2_valid)
    else $error("result lost between stage 1 and stage 2");

  // a stalled stage 2 stays valid and keeps its frame flag
  a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid && !s2_free |=> s2_valid && $stable(s2_frame_end))
    else $error("stage 2 changed while stalled");

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import crf_pkg::*;

  localparam int CFG_W          = 3 * COEF_BITS_DEF;
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PIXELS  = 300;
  localparam int CALM_PIXELS    = 150;
  localparam int CUT_COLUMNS    = 16;

  localparam logic [MODE_W-1:0]    SCALE_SPARE    = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LOW  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HIGH = 3'd7;

  localparam logic [CFG_W-1:0] KERNEL_ZERO     = 24'h000000;
  localparam logic [CFG_W-1:0] KERNEL_CENTRE   = 24'h000100;
  localparam logic [CFG_W-1:0] KERNEL_BOX      = 24'h010101;
  localparam logic [CFG_W-1:0] KERNEL_POS_MAX  = 24'h7F7F7F;
  localparam logic [CFG_W-1:0] KERNEL_NEG_MAX  = 24'h808080;
  localparam logic [CFG_W-1:0] KERNEL_NEG_ONE  = 24'hFFFFFF;
  localparam logic [CFG_W-1:0] KERNEL_SOBEL_OU = 24'h0100FF;
  localparam logic [CFG_W-1:0] KERNEL_SOBEL_IN = 24'h0200FE;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             frame_end;
  } filtered_px_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  crf_in_if  in_pix ();
  crf_out_if out_pix ();

  conv3x3_raster_filter_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_pix    (in_pix),
    .out_pix   (out_pix),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // own copy of the registers and of the filter's storage
  logic [WIDTH_REG_W-1:0]  width_reg   = WIDTH_REG_W'(WIDTH_RESET);
  logic [HEIGHT_REG_W-1:0] height_reg  = HEIGHT_REG_W'(HEIGHT_RESET);
  logic [CFG_W-1:0]        kernel_rows [3] = '{KERNEL_ZERO, KERNEL_CENTRE, KERNEL_ZERO};
  logic [MODE_W-1:0]       mode_reg    = SCALE_DIV9;
  logic [PIX_W-1:0]        line_prev   [MAX_WIDTH_DEF];
  logic [PIX_W-1:0]        line_prev2  [MAX_WIDTH_DEF];
  logic [PIX_W-1:0]        nbhd        [3][3];  // [column slot][row slot]
  int unsigned             col_pos = 0;
  int unsigned             row_pos = 0;

  filtered_px_t queued_px [$];
  int           pixels_sent    = 0;
  int           mismatch_count = 0;
  int           quiet_cycles   = 0;
  int           stall_left     = 0;
  bit           src_gaps_on    = 1'b1;
  bit           sink_stalls_on = 1'b1;

  function automatic int unsigned active_width();
    if (width_reg == 0) return 1;
    if (width_reg > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
    return int'(width_reg);
  endfunction

  function automatic int unsigned active_height();
    return (height_reg == 0) ? 1 : int'(height_reg);
  endfunction

  function automatic void nbhd_shift(input logic [PIX_W-1:0] t, m, b);
    nbhd[0] = nbhd[1];
    nbhd[1] = nbhd[2];
    nbhd[2] = '{t, m, b};
  endfunction

  function automatic logic [PIX_W-1:0] scaled_window_sum();
    longint                          acc;
    longint                          q;
    logic signed [COEF_BITS_DEF-1:0] coef;
    acc = 0;
    // flipped kernel: coefficient (v,u) meets the pixel at slot (2-u, 2-v)
    for (int v = 0; v < 3; v++) begin
      for (int u = 0; u < 3; u++) begin
        coef = kernel_rows[v][u*COEF_BITS_DEF +: COEF_BITS_DEF];
        acc += longint'(coef) * longint'(nbhd[2-u][2-v]);
      end
    end
    case (mode_reg)
      SCALE_DIV16: q = (acc < 0) ? -1 : acc / 16;
      SCALE_SOBEL: q = (acc + SOBEL_OFFSET < 0) ? -1 : (acc + SOBEL_OFFSET) / 8;
      default:     q = (acc < 0) ? -1 : acc / 9;
    endcase
    if (q < 0) q = 0;
    if (q > 255) q = 255;
    return q[PIX_W-1:0];
  endfunction

  function automatic bit convolve_step(input logic [PIX_W-1:0] pix_in, input logic flush,
                                       output filtered_px_t res);
    int unsigned      w;
    int unsigned      h;
    int unsigned      c;
    int unsigned      r;
    logic [PIX_W-1:0] pix;
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    bit               produced;
    w = active_width();
    h = active_height();
    produced = 1'b0;
    res = '0;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    c = col_pos;
    r = row_pos;
    pix = (!flush && r < h) ? pix_in : '0;
    top = (r >= 2 && r - 2 < h) ? line_prev2[c] : '0;
    mid = (r >= 1 && r - 1 < h) ? line_prev[c] : '0;
    if (c == 0) begin
      // zero column on the right closes row r-2
      nbhd_shift('0, '0, '0);
      if (r >= 2 && r - 2 < h) begin
        res.pix = scaled_window_sum();
        res.frame_end = (r - 2 == h - 1);
        produced = 1'b1;
      end
      nbhd = '{default: '0};
      if (r >= h + 1) begin
        col_pos = 0;
        row_pos = 0;
        return produced;
      end
      nbhd[2] = '{top, mid, pix};
    end else begin
      nbhd_shift(top, mid, pix);
      if (r >= 1 && r - 1 < h) begin
        res.pix = scaled_window_sum();
        produced = 1'b1;
      end
    end
    line_prev2[c] = line_prev[c];
    line_prev[c] = pix;
    col_pos = c + 1;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos = r + 1;
    end
    return produced;
  endfunction

  // called at a falling edge, returns at the falling edge after the transaction
  task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic flush);
    filtered_px_t res;
    int           gap;
    if (src_gaps_on && $urandom_range(0, 9) == 0) begin
      in_pix.valid <= 1'b0;
      gap = $urandom_range(1, 12);
      repeat (gap) @(negedge clk);
    end
    in_pix.valid    <= 1'b1;
    in_pix.pixel_in <= pix;
    in_pix.flush    <= flush;
    @(posedge clk);
    while (!in_pix.ready) @(posedge clk);
    if (convolve_step(pix, flush, res)) queued_px.push_back(res);
    pixels_sent++;
    @(negedge clk);
  endtask

  task automatic hold_input_until_drained();
    in_pix.valid <= 1'b0;
    while (queued_px.size() != 0) @(negedge clk);
    // drain items give no result but may still be in flight
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // drain items until the frame restarts; noise_pct of them carry a live pixel
  task automatic finish_frame(input int noise_pct);
    while (col_pos != 0 || row_pos != 0)
      send_pixel(PIX_W'($urandom), $urandom_range(0, 99) >= noise_pct);
  endtask

  task automatic send_frame(input int fixed_pix, input bit messy);
    int               total;
    logic [PIX_W-1:0] pix;
    logic             flush;
    total = active_width() * active_height();
    if (messy && $urandom_range(0, 5) == 0) total = $urandom_range(0, total);
    for (int n = 0; n < total; n++) begin
      pix = (fixed_pix < 0) ? PIX_W'($urandom) : PIX_W'(fixed_pix);
      flush = messy && ($urandom_range(0, 29) == 0);
      send_pixel(pix, flush);
    end
    finish_frame(messy ? 12 : 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    case (idx)
      CFG_IMAGE_WIDTH:  width_reg = value[WIDTH_REG_W-1:0];
      CFG_IMAGE_HEIGHT: height_reg = value[HEIGHT_REG_W-1:0];
      CFG_COEF_TOP:     kernel_rows[0] = value;
      CFG_COEF_MID:     kernel_rows[1] = value;
      CFG_COEF_BOT:     kernel_rows[2] = value;
      CFG_SCALE_MODE:   mode_reg = value[MODE_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_geometry(input logic [WIDTH_REG_W-1:0] w,
                              input logic [HEIGHT_REG_W-1:0] h);
    write_reg(CFG_IMAGE_WIDTH, CFG_W'(w));
    write_reg(CFG_IMAGE_HEIGHT, CFG_W'(h));
  endtask

  task automatic set_kernel(input logic [CFG_W-1:0] top, mid, bot,
                            input logic [MODE_W-1:0] mode);
    write_reg(CFG_COEF_TOP, top);
    write_reg(CFG_COEF_MID, mid);
    write_reg(CFG_COEF_BOT, bot);
    write_reg(CFG_SCALE_MODE, CFG_W'(mode));
  endtask

  function automatic logic [CFG_W-1:0] small_kernel_row();
    logic [CFG_W-1:0] row;
    for (int u = 0; u < 3; u++)
      row[u*COEF_BITS_DEF +: COEF_BITS_DEF] = COEF_BITS_DEF'($urandom_range(0, 4) - 2);
    return row;
  endfunction

  task automatic random_setup();
    logic [WIDTH_REG_W-1:0] w;
    case ($urandom_range(0, 9))
      0:       w = WIDTH_REG_W'($urandom_range(0, 1));
      1:       w = WIDTH_REG_W'($urandom_range(13, 48));
      default: w = WIDTH_REG_W'($urandom_range(2, 12));
    endcase
    set_geometry(w, HEIGHT_REG_W'($urandom_range(0, 6)));
    case ($urandom_range(0, 3))
      0: set_kernel(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom),
                    MODE_W'($urandom_range(0, 3)));
      1: set_kernel(small_kernel_row(), small_kernel_row(), small_kernel_row(),
                    MODE_W'($urandom_range(0, 3)));
      2: set_kernel(KERNEL_BOX, KERNEL_BOX, KERNEL_BOX, SCALE_DIV9);
      default: set_kernel(KERNEL_SOBEL_OU, KERNEL_SOBEL_IN, KERNEL_SOBEL_OU, SCALE_SOBEL);
    endcase
  endtask

  // reset kernel and scaling, then a width cut below the current column
  task automatic test_reset_defaults();
    send_pixel(PIX_MAX, 1'b0);
    send_pixel('0, 1'b0);
    send_pixel(8'd128, 1'b1);
    send_pixel(8'd7, 1'b0);
    hold_input_until_drained();
    set_geometry(3, 2);
    repeat (5) send_pixel(PIX_W'($urandom), 1'b0);
    finish_frame(0);
  endtask

  task automatic test_kernel_extremes();
    hold_input_until_drained();
    set_geometry(3, 2);
    set_kernel(KERNEL_POS_MAX, KERNEL_POS_MAX, KERNEL_POS_MAX, SCALE_DIV16);
    send_frame(PIX_MAX, 1'b0);
    hold_input_until_drained();
    set_kernel(KERNEL_NEG_MAX, KERNEL_NEG_MAX, KERNEL_NEG_MAX, SCALE_SOBEL);
    send_frame(PIX_MAX, 1'b0);
    hold_input_until_drained();
    set_kernel(KERNEL_NEG_ONE, KERNEL_NEG_ONE, KERNEL_NEG_ONE, SCALE_DIV9);
    send_frame(-1, 1'b0);
    hold_input_until_drained();
    set_kernel(KERNEL_ZERO, KERNEL_ZERO, KERNEL_ZERO, SCALE_SOBEL);
    send_frame(0, 1'b0);
  endtask

  task automatic test_scale_modes();
    logic [MODE_W-1:0] modes [4] = '{SCALE_DIV9, SCALE_DIV16, SCALE_SOBEL, SCALE_SPARE};
    foreach (modes[i]) begin
      hold_input_until_drained();
      set_geometry(2, 2);
      set_kernel(small_kernel_row(), small_kernel_row(), small_kernel_row(), modes[i]);
      send_frame(-1, 1'b0);
    end
  endtask

  task automatic test_frame_sizes();
    hold_input_until_drained();
    set_kernel(KERNEL_SOBEL_OU, KERNEL_SOBEL_IN, KERNEL_SOBEL_OU, SCALE_SOBEL);
    set_geometry(0, 0);
    send_frame(-1, 1'b0);
    hold_input_until_drained();
    set_geometry(1, 1);
    send_frame(-1, 1'b0);
    hold_input_until_drained();
    // wider than the line store, clips to full width: one full row, then the
    // second row is cut short by a narrower width
    set_geometry('1, 1);
    repeat (MAX_WIDTH_DEF + CUT_COLUMNS) send_pixel(PIX_W'($urandom), 1'b0);
    hold_input_until_drained();
    set_geometry(CUT_COLUMNS, 1);
    finish_frame(0);
    // tallest frame, cut short: the next row start lies past the new height
    hold_input_until_drained();
    set_geometry(1, '1);
    repeat (5) send_pixel(PIX_W'($urandom), 1'b0);
    hold_input_until_drained();
    set_geometry(1, 2);
    send_pixel(PIX_W'($urandom), 1'b0);
    finish_frame(0);
  endtask

  task automatic test_spare_indices();
    hold_input_until_drained();
    set_geometry(4, 2);
    write_reg(CFG_SPARE_LOW, '1);
    write_reg(CFG_SPARE_HIGH, '1);
    send_frame(-1, 1'b0);
  endtask

  // flush inside the frame and live pixels during the drain
  task automatic test_stream_noise();
    hold_input_until_drained();
    set_geometry(4, 3);
    set_kernel(KERNEL_BOX, KERNEL_BOX, KERNEL_BOX, SCALE_DIV9);
    for (int n = 0; n < 12; n++) send_pixel(PIX_W'($urandom), n == 5);
    finish_frame(100);
  endtask

  task automatic test_random_frames(input int target, input bit allow_idle);
    int stop_at;
    stop_at = pixels_sent + target;
    while (pixels_sent < stop_at) begin
      if (allow_idle && $urandom_range(0, 2) != 0) begin
        hold_input_until_drained();
        random_setup();
      end
      src_gaps_on    = allow_idle && ($urandom_range(0, 3) != 0);
      sink_stalls_on = allow_idle && ($urandom_range(0, 3) != 0);
      send_frame(-1, $urandom_range(0, 3) == 0);
    end
  endtask

  always @(negedge clk) begin
    if (sink_stalls_on && stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_pix.ready <= 1'b0;
    end else if (sink_stalls_on && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 11);
      out_pix.ready <= 1'b0;
    end else begin
      out_pix.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_results
    filtered_px_t want;
    if (rst_n && out_pix.valid && out_pix.ready) begin
      if (queued_px.size() == 0) begin
        $error("unexpected result: pixel_out %0d frame_end %0b",
               out_pix.pixel_out, out_pix.frame_end);
        mismatch_count++;
      end else begin
        want = queued_px.pop_front();
        if (out_pix.pixel_out !== want.pix) begin
          $error("pixel_out: expected %0d, got %0d", want.pix, out_pix.pixel_out);
          mismatch_count++;
        end
        if (out_pix.frame_end !== want.frame_end) begin
          $error("frame_end: expected %0b, got %0b", want.frame_end, out_pix.frame_end);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_pix.valid && in_pix.ready) || (out_pix.valid && out_pix.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("conv3x3_raster_filter_unit verification failed");
        $finish;
      end
    end
  end

  initial begin
    in_pix.valid    = 1'b0;
    in_pix.pixel_in = '0;
    in_pix.flush    = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = CFG_IMAGE_WIDTH;
    cfg_wdata       = '0;
    rst_n           = 1'b0;
    nbhd = '{default: '0};
    foreach (line_prev[i]) begin
      line_prev[i] = '0;
      line_prev2[i] = '0;
    end
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_kernel_extremes();
    test_scale_modes();
    test_frame_sizes();
    test_spare_indices();
    test_stream_noise();
    test_random_frames(RANDOM_PIXELS, 1'b1);
    test_random_frames(CALM_PIXELS, 1'b0);
    hold_input_until_drained();
    if (mismatch_count == 0) begin
      $display("conv3x3_raster_filter_unit verification clean");
    end else begin
      $display("conv3x3_raster_filter_unit verification failed");
    end
    $finish;
  end

endmodule
